[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame tracker checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ELFT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ELFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/elft_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// elft_pkg
// Types and constants shared by the LRU frame tracker modules.
// ---------------------------------------------------------------------------
package elft_pkg;

  // Frame set and link encoding; the null link is the value FRAMES
  localparam int FRAMES  = 64;
  localparam int FRAME_W = $clog2(FRAMES);
  localparam int LINK_W  = $clog2(FRAMES + 1);
  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(FRAMES);

  // Stream field widths
  localparam int IDX_W  = 6;
  localparam int DATA_W = 8;

  typedef enum logic {
    OP_REFERENCE = 1'b0,
    OP_EVICT     = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REF_RD,
    ST_REF_W2,
    ST_REF_W3,
    ST_EV_RD
  } state_t;

  // Request from the sequencer to the link store
  typedef struct packed {
    logic              rd_en;
    logic [FRAME_W-1:0] rd_addr;
    logic              next_we;
    logic [FRAME_W-1:0] next_waddr;
    logic [LINK_W-1:0]  next_wdata;
    logic              prev_we;
    logic [FRAME_W-1:0] prev_waddr;
    logic [LINK_W-1:0]  prev_wdata;
  } link_req_t;

  // Read response from the link store
  typedef struct packed {
    logic [LINK_W-1:0] next_link;
    logic [LINK_W-1:0] prev_link;
  } link_rd_t;

  // True when the frame index names a tracked frame
  function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
    logic res;
    res = (32'(idx) < FRAMES);
    return res;
  endfunction

endpackage

[hw/rtl/elft_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// elft_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module elft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/elft_links.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// elft_links
// Next and prev link memories with per-entry valid bits; an entry never
// written since reset reads as the null link.
// ---------------------------------------------------------------------------
module elft_links (
  input  logic                clk,
  input  logic                rst_n,
  input  elft_pkg::link_req_t req,
  output elft_pkg::link_rd_t  rsp
);

  logic [elft_pkg::FRAMES-1:0] next_vld_r;
  logic [elft_pkg::FRAMES-1:0] prev_vld_r;
  logic                        next_hit_r;
  logic                        prev_hit_r;
  logic [elft_pkg::LINK_W-1:0] next_q;
  logic [elft_pkg::LINK_W-1:0] prev_q;

  elft_ram #(
    .WIDTH (elft_pkg::LINK_W),
    .DEPTH (elft_pkg::FRAMES)
  ) u_next_ram (
    .clk   (clk),
    .we    (req.next_we),
    .waddr (req.next_waddr),
    .wdata (req.next_wdata),
    .re    (req.rd_en),
    .raddr (req.rd_addr),
    .rdata (next_q)
  );

  elft_ram #(
    .WIDTH (elft_pkg::LINK_W),
    .DEPTH (elft_pkg::FRAMES)
  ) u_prev_ram (
    .clk   (clk),
    .we    (req.prev_we),
    .waddr (req.prev_waddr),
    .wdata (req.prev_wdata),
    .re    (req.rd_en),
    .raddr (req.rd_addr),
    .rdata (prev_q)
  );

  // Mark entries written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_vld_r <= '0;
      prev_vld_r <= '0;
    end else begin
      if (req.next_we) begin
        next_vld_r[req.next_waddr] <= 1'b1;
      end
      if (req.prev_we) begin
        prev_vld_r[req.prev_waddr] <= 1'b1;
      end
    end
  end

  // Capture valid bits alongside the RAM read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      next_hit_r <= next_vld_r[req.rd_addr];
      prev_hit_r <= prev_vld_r[req.rd_addr];
    end
  end

  // Substitute null for entries never written
  assign rsp.next_link = next_hit_r ? next_q : elft_pkg::NIL_LINK;
  assign rsp.prev_link = prev_hit_r ? prev_q : elft_pkg::NIL_LINK;

endmodule

[hw/rtl/elft_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// elft_ctrl
// Sequencer for reference and evict transactions: holds head and tail,
// drives link memory reads and writes, and owns the result register.
// ---------------------------------------------------------------------------
module elft_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_op,
  input  logic [elft_pkg::IDX_W-1:0]   in_idx,
  input  elft_pkg::link_rd_t           link_rd,
  output elft_pkg::link_req_t          link_req,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [elft_pkg::IDX_W-1:0]   out_frame,
  output logic                         out_flag
);

  elft_pkg::state_t              state_r, state_nxt;
  logic [elft_pkg::LINK_W-1:0]   head_r, head_nxt;
  logic [elft_pkg::LINK_W-1:0]   tail_r, tail_nxt;
  logic [elft_pkg::FRAME_W-1:0]  frame_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [elft_pkg::IDX_W-1:0]    out_frame_r, out_frame_nxt;
  logic                          out_flag_r, out_flag_nxt;
  logic                          accept;
  logic                          is_evict;
  logic                          ref_move;
  logic                          out_free;
  logic [elft_pkg::LINK_W-1:0]   idx_link;
  logic [elft_pkg::LINK_W-1:0]   p_link;
  logic [elft_pkg::LINK_W-1:0]   n_link;

  assign in_ready = (state_r == elft_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_evict = (elft_pkg::op_t'(in_op) == elft_pkg::OP_EVICT);
  assign idx_link = elft_pkg::LINK_W'(in_idx);
  assign out_free = !out_valid_r || out_ready;
  assign p_link   = link_rd.prev_link;
  assign n_link   = link_rd.next_link;

  // Reference of any frame other than the head of a non-empty list needs the link walk
  assign ref_move = !is_evict && elft_pkg::idx_in_range(in_idx) &&
                    (head_r != elft_pkg::NIL_LINK) && (idx_link != head_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      elft_pkg::ST_IDLE: begin
        if (accept && is_evict) begin
          state_nxt = elft_pkg::ST_EV_RD;
        end else if (accept && ref_move) begin
          state_nxt = elft_pkg::ST_REF_RD;
        end
      end
      elft_pkg::ST_REF_RD: state_nxt = elft_pkg::ST_REF_W2;
      elft_pkg::ST_REF_W2: state_nxt = elft_pkg::ST_REF_W3;
      elft_pkg::ST_REF_W3: state_nxt = elft_pkg::ST_IDLE;
      elft_pkg::ST_EV_RD: begin
        if (out_free) begin
          state_nxt = elft_pkg::ST_IDLE;
        end
      end
      default: state_nxt = elft_pkg::ST_IDLE;
    endcase
  end

  // Memory requests, head/tail updates and result load
  always_comb begin
    link_req      = '0;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_frame_nxt = out_frame_r;
    out_flag_nxt  = out_flag_r;
    unique case (state_r)
      elft_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_evict) begin
            // Fetch the tail's prev link
            link_req.rd_en   = (tail_r != elft_pkg::NIL_LINK);
            link_req.rd_addr = elft_pkg::FRAME_W'(tail_r);
          end else if (ref_move) begin
            link_req.rd_en   = 1'b1;
            link_req.rd_addr = elft_pkg::FRAME_W'(in_idx);
          end else if (elft_pkg::idx_in_range(in_idx) &&
                       (head_r == elft_pkg::NIL_LINK)) begin
            // First frame into an empty list
            head_nxt = idx_link;
            tail_nxt = idx_link;
          end
        end
      end
      elft_pkg::ST_REF_RD: begin
        // Point the frame at the old head and back-link the old head
        link_req.next_we    = 1'b1;
        link_req.next_waddr = frame_r;
        link_req.next_wdata = head_r;
        link_req.prev_we    = 1'b1;
        link_req.prev_waddr = elft_pkg::FRAME_W'(head_r);
        link_req.prev_wdata = elft_pkg::LINK_W'(frame_r);
      end
      elft_pkg::ST_REF_W2: begin
        // Frame becomes head; bridge its old predecessor forward
        link_req.prev_we    = 1'b1;
        link_req.prev_waddr = frame_r;
        link_req.prev_wdata = elft_pkg::NIL_LINK;
        link_req.next_we    = (p_link != elft_pkg::NIL_LINK);
        link_req.next_waddr = elft_pkg::FRAME_W'(p_link);
        link_req.next_wdata = n_link;
        head_nxt            = elft_pkg::LINK_W'(frame_r);
      end
      elft_pkg::ST_REF_W3: begin
        // Bridge the old successor back, or retreat the tail
        link_req.prev_we    = (n_link != elft_pkg::NIL_LINK);
        link_req.prev_waddr = elft_pkg::FRAME_W'(n_link);
        link_req.prev_wdata = p_link;
        if ((n_link == elft_pkg::NIL_LINK) && (p_link != elft_pkg::NIL_LINK)) begin
          tail_nxt = p_link;
        end
      end
      elft_pkg::ST_EV_RD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_flag_nxt  = (tail_r != elft_pkg::NIL_LINK);
          out_frame_nxt = (tail_r != elft_pkg::NIL_LINK) ?
                          elft_pkg::IDX_W'(tail_r) : '0;
          if (tail_r != elft_pkg::NIL_LINK) begin
            if (p_link != elft_pkg::NIL_LINK) begin
              // Unlink the victim from its predecessor
              link_req.next_we    = 1'b1;
              link_req.next_waddr = elft_pkg::FRAME_W'(p_link);
              link_req.next_wdata = elft_pkg::NIL_LINK;
              link_req.prev_we    = 1'b1;
              link_req.prev_waddr = elft_pkg::FRAME_W'(tail_r);
              link_req.prev_wdata = elft_pkg::NIL_LINK;
              tail_nxt            = p_link;
            end else begin
              // Last frame leaves: list empties
              head_nxt = elft_pkg::NIL_LINK;
              tail_nxt = elft_pkg::NIL_LINK;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= elft_pkg::ST_IDLE;
      head_r      <= elft_pkg::NIL_LINK;
      tail_r      <= elft_pkg::NIL_LINK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      frame_r <= elft_pkg::FRAME_W'(in_idx);
    end
    out_frame_r <= out_frame_nxt;
    out_flag_r  <= out_flag_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_frame = out_frame_r;
  assign out_flag  = out_flag_r;

endmodule

[hw/rtl/exact_lru_frame_tracker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// exact_lru_frame_tracker
// Exact LRU recency list over page frames, kept as next/prev links in RAM.
// ---------------------------------------------------------------------------
// Usage: send a reference transaction (in_tuser = 0, frame in in_tdata) to
// make a frame most recent, or an evict transaction (in_tuser = 1) to pull
// the least recent frame; each evict returns one result with out_tuser = 1
// and the victim in out_tdata, or out_tuser = 0 and frame 0 when the list is
// empty. References return nothing. One transaction is in flight at a time.
// A reference that moves a listed frame issues one link read, then link
// writes in ST_REF_RD, ST_REF_W2 and ST_REF_W3, set by the single write
// port of each link memory; there is no link walk when the list is empty
// or the frame is already the head. An evict holds in ST_EV_RD while the
// result register waits on out_tready. Link entries have valid bits cleared
// at reset, so no clearing pass is needed and the block is ready right away.
module exact_lru_frame_tracker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [elft_pkg::DATA_W-1:0] in_tdata,   // [5:0] frame_index
  input  logic                        in_tuser,   // [0] op
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [elft_pkg::DATA_W-1:0] out_tdata,  // [5:0] victim_frame
  output logic                        out_tuser   // [0] victim_valid
);

  elft_pkg::link_req_t          link_req;
  elft_pkg::link_rd_t           link_rd;
  logic [elft_pkg::IDX_W-1:0]   victim_frame;

  elft_links u_links (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (link_req),
    .rsp   (link_rd)
  );

  elft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_idx    (in_tdata[elft_pkg::IDX_W-1:0]),
    .link_rd   (link_rd),
    .link_req  (link_req),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_frame (victim_frame),
    .out_flag  (out_tuser)
  );

  // Pad the victim frame to whole bytes
  assign out_tdata = elft_pkg::DATA_W'(victim_frame);

endmodule

[hw/rtl/elft_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// elft_checker
// Port-level assertions for the LRU frame tracker, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module elft_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        in_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [elft_pkg::DATA_W-1:0] out_tdata,
  input logic                        out_tuser
);

  // A stalled result stays offered
  `ELFT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")

  // An empty-list result reports frame 0
  `ELFT_ASSERT_NOW(a_empty_zero, clk, rst_n, out_tvalid && !out_tuser, out_tdata == '0, "empty evict with nonzero frame")

  // An evict occupies the block for its read cycle
  `ELFT_ASSERT_NEXT(a_evict_busy, clk, rst_n, in_tvalid && in_tready && in_tuser, !in_tready, "evict did not hold off input")

  // A new result follows a busy cycle
  `ELFT_ASSERT_NOW(a_out_after_busy, clk, rst_n, $rose(out_tvalid), !$past(in_tready), "result without evict sequence")

endmodule

bind exact_lru_frame_tracker elft_checker u_elft_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
